[design/afd_pkg.sv]
`default_nettype none

package afd_pkg;

  // sample and magnitude widths
  localparam int SAMPLE_BITS = 16;
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int MAG_W       = SQ_W + 2;
  localparam int MAG_OUT_W   = 32;
  localparam int CMP_W       = (MAG_W > MAG_OUT_W) ? MAG_W : MAG_OUT_W + 1;

  // configuration registers
  localparam int LEVEL_W    = 15;
  localparam int LEVEL_SQ_W = 2 * LEVEL_W;
  localparam int INTERVAL_W = 16;
  localparam int CHECKS_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FREE_FALL_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVEMENT_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_INTERVAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WATCH_CHECKS    = 3'd4;

  // levels are held squared
  localparam logic [LEVEL_SQ_W-1:0] FREE_FALL_SQ_RST = LEVEL_SQ_W'(1280 * 1280);
  localparam logic [LEVEL_SQ_W-1:0] IMPACT_SQ_RST    = LEVEL_SQ_W'(6400 * 6400);
  localparam logic [LEVEL_SQ_W-1:0] MOVEMENT_SQ_RST  = LEVEL_SQ_W'(3072 * 3072);
  localparam logic [INTERVAL_W-1:0] CHECK_INTERVAL_RST = INTERVAL_W'(100);
  localparam logic [CHECKS_W-1:0]   WATCH_CHECKS_RST   = CHECKS_W'(3);

  // detector phases
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ARMED     = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WATCH     = 2'd2;
  localparam logic [PHASE_W-1:0] PH_CONFIRMED = 2'd3;

  // queue between front and back
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  // result skid queue in the back, power of two deep
  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CMP_W-1:0] MAG_MAX = CMP_W'(33'h0_FFFF_FFFF);

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [MAG_OUT_W-1:0] magnitude_squared;
    logic [PHASE_W-1:0]   phase;
    logic                 free_fall_event;
    logic                 impact_event;
    logic                 false_alarm;
    logic                 fall_confirmed;
  } out_word_t;

  // saturate the full-width sum to the 32-bit result field
  function automatic logic [MAG_OUT_W-1:0] sat_mag(input mag_t m);
    logic [CMP_W-1:0] w;
    w = CMP_W'(m);
    if (w > MAG_MAX) begin
      sat_mag = '1;
    end else begin
      sat_mag = MAG_OUT_W'(w);
    end
  endfunction

endpackage

`default_nettype wire

[design/afd_front.sv]
`default_nettype none

module afd_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire afd_pkg::in_word_t              in_word,
  input  wire logic [afd_pkg::MID_CNT_W-1:0]  mid_count,
  output logic                                in_full,
  output logic                                mag_push,
  output afd_pkg::mag_t                       mag_data
);

  logic                          accept;
  logic [afd_pkg::SAMPLE_BITS-1:0] abs_x, abs_y, abs_z;
  logic                          v1_r, v2_r;
  logic [afd_pkg::SQ_W-1:0]      sq_x_r, sq_y_r, sq_z_r;
  afd_pkg::mag_t                 mag_r;
  logic [afd_pkg::MID_CNT_W:0]   used;

  // credits: queue fill plus words still in the two stages
  assign used    = (afd_pkg::MID_CNT_W + 1)'(mid_count)
                 + (afd_pkg::MID_CNT_W + 1)'(v1_r)
                 + (afd_pkg::MID_CNT_W + 1)'(v2_r);
  assign in_full = used >= (afd_pkg::MID_CNT_W + 1)'(afd_pkg::MID_DEPTH);
  assign accept  = in_push && !in_full;

  // two's complement magnitude, the most negative value maps to its unsigned twin
  assign abs_x = in_word.accel_x[afd_pkg::SAMPLE_BITS-1] ? -in_word.accel_x : in_word.accel_x;
  assign abs_y = in_word.accel_y[afd_pkg::SAMPLE_BITS-1] ? -in_word.accel_y : in_word.accel_y;
  assign abs_z = in_word.accel_z[afd_pkg::SAMPLE_BITS-1] ? -in_word.accel_z : in_word.accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_x_r <= afd_pkg::SQ_W'(abs_x) * afd_pkg::SQ_W'(abs_x);
    sq_y_r <= afd_pkg::SQ_W'(abs_y) * afd_pkg::SQ_W'(abs_y);
    sq_z_r <= afd_pkg::SQ_W'(abs_z) * afd_pkg::SQ_W'(abs_z);
    mag_r  <= afd_pkg::MAG_W'(sq_x_r) + afd_pkg::MAG_W'(sq_y_r) + afd_pkg::MAG_W'(sq_z_r);
  end

  assign mag_push = v2_r;
  assign mag_data = mag_r;

endmodule

`default_nettype wire

[design/afd_queue.sv]
`default_nettype none

module afd_queue (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire afd_pkg::mag_t                  push_data,
  input  wire logic                           pop,
  output logic                                empty,
  output afd_pkg::mag_t                       head,
  output logic [afd_pkg::MID_CNT_W-1:0]       count
);

  afd_pkg::mag_t                   mem_r [afd_pkg::MID_DEPTH];
  logic [afd_pkg::MID_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [afd_pkg::MID_CNT_W-1:0]   count_r, count_nxt;

  // push is credit controlled upstream, never lands on a full queue
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + afd_pkg::MID_CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - afd_pkg::MID_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + afd_pkg::MID_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + afd_pkg::MID_PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

[design/afd_back.sv]
`default_nettype none

module afd_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            mid_empty,
  input  wire afd_pkg::mag_t                   mid_head,
  output logic                                 mid_pop,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output afd_pkg::out_word_t                   out_word
);

  logic [afd_pkg::LEVEL_SQ_W-1:0] ff_sq_r, imp_sq_r, mov_sq_r;
  logic [afd_pkg::INTERVAL_W-1:0] interval_r;
  logic [afd_pkg::CHECKS_W-1:0]   watch_r;
  logic [afd_pkg::LEVEL_W-1:0]    lvl;
  logic [afd_pkg::LEVEL_SQ_W-1:0] lvl_sq;

  logic [afd_pkg::PHASE_W-1:0]    phase_r, phase_nxt;
  logic [afd_pkg::INTERVAL_W-1:0] cnt_r, cnt_nxt, cnt_inc, period;
  logic [afd_pkg::CHECKS_W-1:0]   quiet_r, quiet_nxt, quiet_inc;

  logic [afd_pkg::CMP_W-1:0]      mag_w;
  logic                           below_ff, above_imp, above_mov;
  logic                           ff_ev, imp_ev, false_ev;
  afd_pkg::out_word_t             res;

  afd_pkg::out_word_t             oq_r [afd_pkg::OUT_DEPTH];
  logic [afd_pkg::OUT_PTR_W-1:0]  oq_wr_r, oq_rd_r;
  logic [afd_pkg::OUT_CNT_W-1:0]  oq_cnt_r;
  logic                           oq_push, oq_pop;

  assign lvl    = afd_pkg::LEVEL_W'(cfg_data);
  assign lvl_sq = afd_pkg::LEVEL_SQ_W'(lvl) * afd_pkg::LEVEL_SQ_W'(lvl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_sq_r    <= afd_pkg::FREE_FALL_SQ_RST;
      imp_sq_r   <= afd_pkg::IMPACT_SQ_RST;
      mov_sq_r   <= afd_pkg::MOVEMENT_SQ_RST;
      interval_r <= afd_pkg::CHECK_INTERVAL_RST;
      watch_r    <= afd_pkg::WATCH_CHECKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        afd_pkg::REG_FREE_FALL_LEVEL: ff_sq_r    <= lvl_sq;
        afd_pkg::REG_IMPACT_LEVEL:    imp_sq_r   <= lvl_sq;
        afd_pkg::REG_MOVEMENT_LEVEL:  mov_sq_r   <= lvl_sq;
        afd_pkg::REG_CHECK_INTERVAL:  interval_r <= afd_pkg::INTERVAL_W'(cfg_data);
        afd_pkg::REG_WATCH_CHECKS:    watch_r    <= afd_pkg::CHECKS_W'(cfg_data);
        default: ;
      endcase
    end
  end

  assign oq_push = !mid_empty
                 && (oq_cnt_r != afd_pkg::OUT_CNT_W'(afd_pkg::OUT_DEPTH));
  assign oq_pop  = out_pop && (oq_cnt_r != '0);
  assign mid_pop = oq_push;

  assign mag_w     = afd_pkg::CMP_W'(mid_head);
  assign below_ff  = mag_w < afd_pkg::CMP_W'(ff_sq_r);
  assign above_imp = mag_w > afd_pkg::CMP_W'(imp_sq_r);
  assign above_mov = mag_w > afd_pkg::CMP_W'(mov_sq_r);

  assign cnt_inc   = cnt_r + afd_pkg::INTERVAL_W'(1);
  assign period    = (interval_r == '0) ? afd_pkg::INTERVAL_W'(1) : interval_r;
  assign quiet_inc = (quiet_r == '1) ? quiet_r : quiet_r + afd_pkg::CHECKS_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    quiet_nxt = quiet_r;
    ff_ev     = 1'b0;
    imp_ev    = 1'b0;
    false_ev  = 1'b0;
    unique case (phase_r) inside
      afd_pkg::PH_IDLE, afd_pkg::PH_ARMED: begin
        ff_ev = below_ff;
        if (below_ff) begin
          phase_nxt = afd_pkg::PH_ARMED;
        end
        // impact sees the arm from this same sample
        if ((below_ff || phase_r == afd_pkg::PH_ARMED) && above_imp) begin
          imp_ev    = 1'b1;
          phase_nxt = afd_pkg::PH_WATCH;
          cnt_nxt   = '0;
          quiet_nxt = '0;
        end
      end
      afd_pkg::PH_WATCH: begin
        if (cnt_inc >= period) begin
          cnt_nxt = '0;
          if (above_mov) begin
            false_ev  = 1'b1;
            phase_nxt = afd_pkg::PH_IDLE;
            quiet_nxt = '0;
          end else begin
            quiet_nxt = quiet_inc;
            if (quiet_inc >= watch_r) begin
              phase_nxt = afd_pkg::PH_CONFIRMED;
            end
          end
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.magnitude_squared = afd_pkg::sat_mag(mid_head);
    res.phase             = phase_nxt;
    res.free_fall_event   = ff_ev;
    res.impact_event      = imp_ev;
    res.false_alarm       = false_ev;
    res.fall_confirmed    = (phase_nxt == afd_pkg::PH_CONFIRMED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= afd_pkg::PH_IDLE;
      cnt_r    <= '0;
      quiet_r  <= '0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        quiet_r <= quiet_nxt;
        oq_wr_r <= oq_wr_r + afd_pkg::OUT_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + afd_pkg::OUT_PTR_W'(1);
      end
      oq_cnt_r <= oq_cnt_r + afd_pkg::OUT_CNT_W'(oq_push) - afd_pkg::OUT_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  assign out_empty = (oq_cnt_r == '0);
  assign out_word  = oq_r[oq_rd_r];

endmodule

`default_nettype wire

[design/accel_fall_detector_core.sv]
// a word goes through square, sum, queue and decide registers before it can be popped
// throughput: one word per cycle sustained, unless a full result queue stalls the back
// the front keeps at most four words in its queue, counting the two in its stages
// reset (rst_n low at a clock edge, synchronous): queues empty, phase idle,
// counters zero, registers back to their default levels
`default_nettype none

module accel_fall_detector_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input word channel
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire afd_pkg::in_word_t               in_word,
  // result word channel
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output afd_pkg::out_word_t                   out_word,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [afd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [afd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // front to queue
  logic                          mag_push;
  afd_pkg::mag_t                 mag_data;
  // queue to back
  logic                          mid_empty;
  logic                          mid_pop;
  afd_pkg::mag_t                 mid_head;
  logic [afd_pkg::MID_CNT_W-1:0] mid_count;

  // front: absolute values, three squarers, then the sum
  afd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_word   (in_word),
    .mid_count (mid_count),
    .in_full   (in_full),
    .mag_push  (mag_push),
    .mag_data  (mag_data)
  );

  // short queue of magnitudes, lets the front run while the back stalls
  afd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mag_push),
    .push_data (mag_data),
    .pop       (mid_pop),
    .empty     (mid_empty),
    .head      (mid_head),
    .count     (mid_count)
  );

  // back: level compares, phase machine, result skid queue
  afd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .mid_empty (mid_empty),
    .mid_head  (mid_head),
    .mid_pop   (mid_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
